/* sv/wav_pcm_stream_decoder_defines.svh */
//------------------------------------------------------------------------------
// wav_pcm_stream_decoder_defines
// Assertion macros shared by the decoder RTL.
//------------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_DECODER_DEFINES_SVH
`define WAV_PCM_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define WPSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decoder check failed");

// next-cycle implication
`define WPSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decoder check failed");

`endif

/* sv/wpsd_pkg.sv */
//------------------------------------------------------------------------------
// wpsd_pkg
// Types and constants of the WAV PCM stream decoder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpsd_pkg;

	localparam int HEADER_BYTES = 44;
	localparam int POS_W        = 6;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

	localparam logic [15:0] FMT_PCM = 16'd1;

	localparam int DIVIDEND_W = 31;
	localparam int DIVISOR_W  = 16;
	localparam int CNT_W      = 5;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 56;
	localparam int RATE_W     = 31;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_SAMPLES = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic {
		ST_RUN = 1'b0,
		ST_DIV = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

endpackage

/* sv/wpsd_div.sv */
//------------------------------------------------------------------------------
// wpsd_div
// Restoring divider, one quotient bit per cycle; done pulses when the
// quotient is ready.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpsd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wpsd_pkg::div_req_t                  req,
	output logic                                done,
	output logic [wpsd_pkg::DIVIDEND_W-1:0]     quotient
);

	localparam logic [wpsd_pkg::CNT_W-1:0] CNT_LAST = wpsd_pkg::CNT_W'(wpsd_pkg::DIVIDEND_W - 1);

	logic                               busy_q;
	logic                               done_q;
	logic [wpsd_pkg::CNT_W-1:0]         cnt_q;
	logic [wpsd_pkg::DIVISOR_W-1:0]     rem_q;
	logic [wpsd_pkg::DIVISOR_W-1:0]     dsr_q;
	logic [wpsd_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [wpsd_pkg::DIVISOR_W:0]       trial;
	logic [wpsd_pkg::DIVISOR_W:0]       diff;
	logic                               fits;

	assign trial = {rem_q, quo_q[wpsd_pkg::DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[wpsd_pkg::DIVISOR_W-1:0] : trial[wpsd_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[wpsd_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* sv/wav_pcm_stream_decoder.sv */
//------------------------------------------------------------------------------
// wav_pcm_stream_decoder
// Parses the canonical 44-byte WAV header from a byte stream, reports a
// status beat, then decodes the PCM data into Q1.15 sample beats.
//------------------------------------------------------------------------------
// Bytes are taken one per cycle while the input is not stalled. After the last
// header byte of an accepted header that does not also end the file, the input
// stalls while the restoring divider forms floor(data_size / block_align), one
// quotient bit per cycle (31 steps, then the sample count is loaded). A waiting
// output beat blocks the input only when the sink does not take it.
`timescale 1ns / 1ps

`include "wav_pcm_stream_decoder_defines.svh"

module wav_pcm_stream_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [wpsd_pkg::IN_DATA_W-1:0]     s_tdata,   // data_byte[7:0]
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// sample_value[15:0], channel_index[16], channel_count[18:17],
	// sample_rate[49:19], zero fill[55:50]
	output logic [wpsd_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [1:0]                         m_tuser,   // kind[1:0]
	output logic                               m_tlast
);

	wpsd_pkg::state_t                    state_q, state_d;
	wpsd_pkg::phase_t                    phase_q, phase_d;
	logic [wpsd_pkg::POS_W-1:0]          pos_q, pos_d;
	logic [31:0]                         left_q, left_d;
	logic [8:0]                          hold_q, hold_d;
	logic                                chan_q, chan_d;

	logic [31:0]                         fmt_size_q;
	logic [15:0]                         format_q;
	logic [15:0]                         channels_q;
	logic [31:0]                         rate_q;
	logic [15:0]                         align_q;
	logic [15:0]                         bits_q;
	logic [31:0]                         data_size_q;

	logic                                m_tvalid_q;
	wpsd_pkg::kind_t                     kind_q, kind_d;
	logic [15:0]                         val_q, val_d;
	logic                                och_q, och_d;
	logic [1:0]                          ocount_q, ocount_d;
	logic [wpsd_pkg::RATE_W-1:0]         orate_q, orate_d;
	logic                                oend_q, oend_d;

	logic                                in_acc;
	logic                                emit;
	logic                                capture_en;
	logic                                hdr_ok;
	logic                                fmt_bad;
	logic [31:0]                         left_dec;
	logic [wpsd_pkg::DIVIDEND_W-1:0]     quotient;
	logic                                div_done;
	wpsd_pkg::div_req_t                  div_req;

	assign fmt_bad = !fmt_size_q[31] && (fmt_size_q[30:0] > 31'd16);
	assign hdr_ok  = (format_q == wpsd_pkg::FMT_PCM) && !fmt_bad && !s_tdata[7]
		&& ((channels_q == 16'd1) || (channels_q == 16'd2))
		&& ((bits_q == 16'd8) || (bits_q == 16'd16))
		&& (align_q != 16'd0);
	assign left_dec = left_q - 32'd1;

	wpsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d          = state_q;
		phase_d          = phase_q;
		pos_d            = pos_q;
		left_d           = left_q;
		hold_d           = hold_q;
		chan_d           = chan_q;
		emit             = 1'b0;
		capture_en       = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {s_tdata[6:0], data_size_q[23:0]};
		div_req.divisor  = align_q;
		kind_d           = wpsd_pkg::KIND_SAMPLE;
		val_d            = '0;
		och_d            = 1'b0;
		ocount_d         = '0;
		orate_d          = '0;
		oend_d           = 1'b0;
		s_tready         = (state_q == wpsd_pkg::ST_RUN) && (!m_tvalid_q || m_tready);
		in_acc           = s_tvalid && s_tready;
		case (state_q)
			wpsd_pkg::ST_RUN: begin
				if (in_acc) begin
					case (phase_q)
						wpsd_pkg::PH_HEADER: begin
							capture_en = 1'b1;
							if (pos_q == wpsd_pkg::POS_LAST) begin
								emit    = 1'b1;
								phase_d = wpsd_pkg::PH_DISCARD;
								if (hdr_ok) begin
									kind_d   = wpsd_pkg::KIND_ACCEPT;
									ocount_d = channels_q[1:0];
									orate_d  = rate_q[wpsd_pkg::RATE_W-1:0];
									if (!s_tlast) begin
										div_req.start = 1'b1;
										state_d       = wpsd_pkg::ST_DIV;
									end
								end else begin
									kind_d = wpsd_pkg::KIND_REJECT;
								end
							end else if (s_tlast) begin
								emit   = 1'b1;
								kind_d = wpsd_pkg::KIND_REJECT;
							end else begin
								pos_d = pos_q + 1'b1;
							end
						end
						wpsd_pkg::PH_SAMPLES: begin
							if (bits_q == 16'd8) begin
								emit  = 1'b1;
								val_d = {s_tdata ^ 8'h80, 8'h00};
							end else if (hold_q[8]) begin
								emit   = 1'b1;
								val_d  = {s_tdata, hold_q[7:0]};
								hold_d = '0;
							end else begin
								hold_d = {1'b1, s_tdata};
							end
							if (emit) begin
								kind_d   = wpsd_pkg::KIND_SAMPLE;
								left_d   = left_dec;
								och_d    = chan_q;
								ocount_d = channels_q[1:0];
								orate_d  = rate_q[wpsd_pkg::RATE_W-1:0];
								oend_d   = (left_dec == 32'd0) || s_tlast;
								chan_d   = (channels_q == 16'd2) ? !chan_q : 1'b0;
								if (left_dec == 32'd0) begin
									phase_d = wpsd_pkg::PH_DISCARD;
								end
							end
						end
						default: ;
					endcase
					if (s_tlast) begin
						pos_d   = '0;
						phase_d = wpsd_pkg::PH_HEADER;
						left_d  = '0;
						hold_d  = '0;
						chan_d  = 1'b0;
					end
				end
			end
			wpsd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = wpsd_pkg::ST_RUN;
					left_d  = channels_q[1] ? {quotient, 1'b0} : {1'b0, quotient};
					phase_d = (left_d != 32'd0) ? wpsd_pkg::PH_SAMPLES : wpsd_pkg::PH_DISCARD;
				end
			end
			default: state_d = wpsd_pkg::ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wpsd_pkg::ST_RUN;
			phase_q    <= wpsd_pkg::PH_HEADER;
			pos_q      <= '0;
			left_q     <= '0;
			hold_q     <= '0;
			chan_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			left_q  <= left_d;
			hold_q  <= hold_d;
			chan_q  <= chan_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture_en) begin
			if (pos_q inside {[16:19]}) begin
				fmt_size_q[{pos_q[1:0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[20:21]}) begin
				format_q[{pos_q[0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[22:23]}) begin
				channels_q[{pos_q[0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[24:27]}) begin
				rate_q[{pos_q[1:0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[32:33]}) begin
				align_q[{pos_q[0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[34:35]}) begin
				bits_q[{pos_q[0], 3'b000} +: 8] <= s_tdata;
			end
			if (pos_q inside {[40:43]}) begin
				data_size_q[{pos_q[1:0], 3'b000} +: 8] <= s_tdata;
			end
		end
		if (emit) begin
			kind_q   <= kind_d;
			val_q    <= val_d;
			och_q    <= och_d;
			ocount_q <= ocount_d;
			orate_q  <= orate_d;
			oend_q   <= oend_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, orate_q, ocount_q, och_q, val_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = oend_q;

	`WPSD_ASSERT_IMP(a_stall_while_div, state_q == wpsd_pkg::ST_DIV, !s_tready)
	`WPSD_ASSERT_IMP(a_done_only_in_div, div_done, state_q == wpsd_pkg::ST_DIV)
	`WPSD_ASSERT_NXT(a_div_after_accept, div_req.start, state_q == wpsd_pkg::ST_DIV && m_tvalid)
	`WPSD_ASSERT_IMP(a_samples_pending, phase_q == wpsd_pkg::PH_SAMPLES, left_q != 32'd0)
	`WPSD_ASSERT_IMP(a_header_pos_range, phase_q == wpsd_pkg::PH_HEADER, pos_q <= wpsd_pkg::POS_LAST)

endmodule
